>>> sv/hxd_pkg.sv
// Shared types, constants and codes of the hex text decoder.
package hxd_pkg;

  localparam int CH_W        = 8;
  localparam int NIB_W       = 4;
  localparam int POS_W       = 17;
  localparam int CNT_W       = 16;
  localparam int MAX_LEN_DEF = 65536;
  localparam int Q_DEPTH     = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Character class decided by the front end
  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_SKIP,
    CLS_NUL,
    CLS_BAD
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD,
    ST_ODD
  } status_t;

  // One classified character as it travels through the queue
  typedef struct packed {
    cls_t             cls;
    logic [NIB_W-1:0] nib;
    logic             last;
  } entry_t;

endpackage

>>> sv/hex_text_decoder.sv
// Hex text decoder top level: front classifier, queue and back end.
// Takes one character beat per cycle while in_ready is high and turns each pair of
// hex digits into a data byte, closing every message with one status beat. The
// classifier is pure logic in front of a four-entry queue, and the back end
// retires one queued character per cycle, while each result is taken, into a
// single result register. A digit that completes a byte on the last character
// yields two results and holds the back end on that character until both are
// loaded; the queue absorbs this and stalls on the result side until it is full,
// when in_ready drops. An accepted character passes a queue slot, then the result
// register. allow_space is to be written only while no message is in flight.
module hex_text_decoder import hxd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CH_W-1:0]  ch,
  input  logic             last_char,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [CH_W-1:0]  data_byte,
  output logic [1:0]       status,
  output logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] byte_count,
  output logic             end_of_run
);

  logic   allow_space;
  entry_t front_entry;
  entry_t head_entry;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_space <= 1'b0;
    end else if (cfg_we) begin
      allow_space <= cfg_data;
    end
  end

  assign in_ready = !q_full;

  hxd_front u_front (
    .ch          (ch),
    .last_char   (last_char),
    .allow_space (allow_space),
    .entry       (front_entry)
  );

  hxd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  hxd_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .allow_space (allow_space),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .status      (status),
    .position    (position),
    .byte_count  (byte_count),
    .end_of_run  (end_of_run)
  );

endmodule

>>> sv/hxd_front.sv
// Front end: classifies each incoming character and converts digits to nibbles.
module hxd_front import hxd_pkg::*; (
  input  logic [CH_W-1:0] ch,
  input  logic            last_char,
  input  logic            allow_space,
  output entry_t          entry
);

  logic is_dec;
  logic is_upper;
  logic is_lower;
  logic is_ws;

  // Sort the character into digit, skipped whitespace, NUL or bad
  always_comb begin
    is_dec   = ch inside {[8'h30:8'h39]};
    is_upper = ch inside {[8'h41:8'h46]};
    is_lower = ch inside {[8'h61:8'h66]};
    is_ws    = ch inside {[8'd9:8'd13], 8'd32};

    entry.last = last_char;
    entry.nib  = '0;
    if (is_dec) begin
      entry.cls = CLS_DIGIT;
      entry.nib = ch[NIB_W-1:0];
    end else if (is_upper || is_lower) begin
      entry.cls = CLS_DIGIT;
      entry.nib = ch[NIB_W-1:0] + NIB_W'(9);
    end else if (is_ws && allow_space) begin
      entry.cls = CLS_SKIP;
    end else if (ch == '0) begin
      entry.cls = CLS_NUL;
    end else begin
      entry.cls = CLS_BAD;
    end
  end

endmodule

>>> sv/hxd_queue.sv
// Short queue of classified characters between front and back end.
module hxd_queue import hxd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  entry_t             slots [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  fill;

  assign full       = (fill == CNT_QW'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_entry = slots[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> sv/hxd_back.sv
// Back end: pairs nibbles, tracks message state and drives the result register.
module hxd_back import hxd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             allow_space,
  input  logic             head_valid,
  input  entry_t           head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [CH_W-1:0]  data_byte,
  output logic [1:0]       status,
  output logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] byte_count,
  output logic             end_of_run
);

  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;

  // Message state
  logic [NIB_W-1:0] high_nibble, high_nibble_next;
  logic             half_pending, half_pending_next;
  logic             stopped, stopped_next;
  logic [IDX_W-1:0] char_index, char_index_next;
  logic [CNT_W-1:0] bytes_done, bytes_done_next;
  logic             phase, phase_next;

  // Result being loaded
  logic             load;
  logic             res_kind;
  logic [CH_W-1:0]  res_data;
  status_t          res_status;
  logic [POS_W-1:0] res_pos;

  logic             go;
  logic             done;
  logic [EXT_W-1:0] idx_ext;
  logic [POS_W-1:0] idx_pos;
  logic [POS_W-1:0] idx_pos1;

  assign go       = head_valid && (!out_valid || out_ready);
  assign idx_ext  = EXT_W'(char_index);
  assign idx_pos  = idx_ext[POS_W-1:0];
  assign idx_pos1 = idx_pos + 1'b1;

  // Execute the head beat of the queue
  always_comb begin
    high_nibble_next  = high_nibble;
    half_pending_next = half_pending;
    stopped_next      = stopped;
    char_index_next   = char_index;
    bytes_done_next   = bytes_done;
    phase_next        = phase;
    pop               = 1'b0;
    load              = 1'b0;
    done              = 1'b0;
    res_kind          = KIND_DATA;
    res_data          = '0;
    res_status        = ST_OK;
    res_pos           = '0;

    if (go) begin
      if (char_index < IDX_W'(MAX_LEN)) begin
        char_index_next = char_index + 1'b1;
      end
      if (phase) begin
        // Closing status after a byte completed on the last character
        res_kind = KIND_STATUS;
        load     = 1'b1;
        pop      = 1'b1;
        phase_next        = 1'b0;
        high_nibble_next  = '0;
        half_pending_next = 1'b0;
        stopped_next      = 1'b0;
        char_index_next   = '0;
        bytes_done_next   = '0;
      end else if (stopped) begin
        pop = 1'b1;
        if (head_entry.last) begin
          high_nibble_next  = '0;
          half_pending_next = 1'b0;
          stopped_next      = 1'b0;
          char_index_next   = '0;
          bytes_done_next   = '0;
        end
      end else begin
        case (head_entry.cls)
          CLS_DIGIT: begin
            if (half_pending) begin
              load     = 1'b1;
              res_data = {high_nibble, head_entry.nib};
              if (bytes_done != CNT_MAX) begin
                bytes_done_next = bytes_done + 1'b1;
              end
              half_pending_next = 1'b0;
              if (head_entry.last) begin
                // Hold the beat for a second result
                phase_next      = 1'b1;
                char_index_next = char_index;
              end else begin
                pop = 1'b1;
              end
            end else begin
              high_nibble_next  = head_entry.nib;
              half_pending_next = 1'b1;
              if (head_entry.last) begin
                done       = 1'b1;
                res_status = ST_ODD;
                res_pos    = allow_space ? idx_pos1 : idx_pos;
              end else begin
                pop = 1'b1;
              end
            end
          end
          CLS_SKIP: begin
            if (head_entry.last) begin
              done = 1'b1;
              if (half_pending) begin
                res_status = ST_ODD;
                res_pos    = idx_pos1;
              end
            end else begin
              pop = 1'b1;
            end
          end
          CLS_NUL: begin
            done = 1'b1;
            if (allow_space && half_pending) begin
              res_status = ST_ODD;
              res_pos    = idx_pos1;
            end
          end
          default: begin
            done       = 1'b1;
            res_status = ST_BAD;
            res_pos    = idx_pos;
          end
        endcase

        if (done) begin
          res_kind = KIND_STATUS;
          load     = 1'b1;
          pop      = 1'b1;
          if (head_entry.last) begin
            high_nibble_next  = '0;
            half_pending_next = 1'b0;
            stopped_next      = 1'b0;
            char_index_next   = '0;
            bytes_done_next   = '0;
          end else begin
            stopped_next = 1'b1;
          end
        end
      end
    end
  end

  // Update message state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_nibble  <= '0;
      half_pending <= 1'b0;
      stopped      <= 1'b0;
      char_index   <= '0;
      bytes_done   <= '0;
      phase        <= 1'b0;
    end else begin
      high_nibble  <= high_nibble_next;
      half_pending <= half_pending_next;
      stopped      <= stopped_next;
      char_index   <= char_index_next;
      bytes_done   <= bytes_done_next;
      phase        <= phase_next;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= res_kind;
      data_byte  <= res_data;
      status     <= res_status;
      position   <= res_pos;
      byte_count <= (res_kind == KIND_STATUS) ? bytes_done : '0;
      end_of_run <= (res_kind == KIND_STATUS);
    end
  end

  // The second result always belongs to a beat still at the queue head
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> head_valid && head_entry.last)
    else $error("second result pending without a last beat at the head");

  // A stopped message never owes a second result
  a_stop_phase: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !phase)
    else $error("stopped while a closing status is pending");

  // Entering the second phase follows the loading of a data byte
  a_phase_data: assert property (@(posedge clk) disable iff (rst)
    $rose(phase) |-> out_valid && (kind == KIND_DATA))
    else $error("closing phase without a data byte loaded");

  // Data beats never close a message
  a_data_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DATA) |-> !end_of_run && (byte_count == '0))
    else $error("data beat carries status fields");

endmodule
